// ===== hdl/sbrc_pkg.sv =====
package sbrc_pkg;

  // Default table depth
  localparam int SbrcSlots = 64;

  localparam int SIZE_W = 48;
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 64;

  // Request type codes
  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // Configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic              any_size;
    logic [SIZE_W-1:0] block_size;
    logic [ADDR_W-1:0] block_addr;
  } in_word_t;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] returned_addr;
    logic [SIZE_W-1:0] bytes_in_cache;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  hit_bytes;
    logic [CNT_W-1:0]  miss_bytes;
  } out_word_t;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } slot_ent_t;

  // Scan outcome handed to the statistics unit
  typedef struct packed {
    logic              vld;
    logic              found;
    in_word_t          req;
    logic [SIZE_W-1:0] slot_size;
    logic [ADDR_W-1:0] slot_addr;
  } upd_t;

endpackage

// ===== hdl/sized_block_reuse_cache.sv =====
// Cache of freed memory blocks, keyed by size.
// Requests: drive in_word and raise start; the word is taken at an edge where
// start is high and busy is low. A put stores (size, address) in the lowest
// free slot if the held bytes stay within the capacity register; a get takes
// the lowest slot of that size, or any valid slot when any_size is set.
// Results: one word per request on out_word, marked by out_strobe for one
// cycle. The receiver cannot stall, so the word must be taken that cycle.
// Timing: the slot table lives in one memory with a registered read and is
// scanned one slot per cycle. The scan stops at the first matching slot, or
// after the last slot when none matches; the outcome then passes through the
// update state into the registered out_word. busy drops the cycle the result
// appears, so a new request is taken only after the previous one is through.
// Reset: rst_n clears the counters and held bytes, then a clearing pass
// marks every slot empty, one slot at a time; busy stays high until it ends.
// Configuration: capacity_bytes at byte address 0 of the APB port. The user
// must see that it is written only while idle; the block does not enforce it.
module sized_block_reuse_cache import sbrc_pkg::*; #(
  parameter int SLOTS = SbrcSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_strobe,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(SLOTS);

  logic [SIZE_W-1:0] capacity_r;
  logic              reg_idx;
  logic              put_fits;
  upd_t              upd;
  logic              mem_rd_en;
  logic [IW-1:0]     mem_rd_addr;
  slot_ent_t         mem_rd_data;
  logic              mem_wr_en;
  logic [IW-1:0]     mem_wr_addr;
  slot_ent_t         mem_wr_data;

  // Register file: one 64-bit word per register
  assign reg_idx = paddr[3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY)) begin
      capacity_r <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_CAPACITY) ? {{(64 - SIZE_W){1'b0}}, capacity_r} : '0;

  sbrc_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  sbrc_scan #(.SLOTS(SLOTS)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .put_fits    (put_fits),
    .upd         (upd),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  sbrc_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (capacity_r),
    .upd        (upd),
    .put_fits   (put_fits),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// ===== hdl/sbrc_slot_mem.sv =====
module sbrc_slot_mem import sbrc_pkg::*; #(
  parameter int SLOTS = SbrcSlots,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output slot_ent_t       rd_data,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  slot_ent_t       wr_data
);

  slot_ent_t mem [SLOTS];
  slot_ent_t rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sbrc_scan.sv =====
module sbrc_scan import sbrc_pkg::*; #(
  parameter int SLOTS = SbrcSlots,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_word_t      in_word,
  input  logic          put_fits,
  output upd_t          upd,
  output logic          mem_rd_en,
  output logic [IW-1:0] mem_rd_addr,
  input  slot_ent_t     mem_rd_data,
  output logic          mem_wr_en,
  output logic [IW-1:0] mem_wr_addr,
  output slot_ent_t     mem_wr_data
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  in_word_t        req_r, req_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  slot_ent_t       hit_ent_r, hit_ent_nxt;
  logic            match;
  logic            issue;

  // Match rule of the pending request against the entry just read
  always_comb begin
    if (req_r.req_type == REQ_PUT) begin
      match = !mem_rd_data.valid;
    end else if (req_r.any_size) begin
      match = mem_rd_data.valid;
    end else begin
      match = mem_rd_data.valid && (mem_rd_data.size == req_r.block_size);
    end
  end

  assign issue = (state_r == ST_SCAN) && (rd_cnt_r < CNT_END);

  // Advance the sequencer
  always_comb begin
    state_nxt   = state_r;
    rd_cnt_nxt  = rd_cnt_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    req_nxt     = req_r;
    found_nxt   = found_r;
    hit_idx_nxt = hit_idx_r;
    hit_ent_nxt = hit_ent_r;
    unique case (state_r)
      ST_CLEAR: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_cnt_r[IW-1:0] == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt    = in_word;
          rd_cnt_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IW-1:0];
        end
        if (chk_vld_r) begin
          if (match) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = chk_idx_r;
            hit_ent_nxt = mem_rd_data;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_UPDATE;
          end else if (chk_idx_r == LAST_IDX) begin
            found_nxt   = 1'b0;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      found_r   <= found_nxt;
    end
  end

  // Hold request and hit payload
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    req_r     <= req_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_ent_r <= hit_ent_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign mem_rd_en   = issue;
  assign mem_rd_addr = rd_cnt_r[IW-1:0];

  // Clear the table after reset, else write back the chosen slot
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = hit_idx_r;
    mem_wr_data = hit_ent_r;
    if (state_r == ST_CLEAR) begin
      mem_wr_en         = 1'b1;
      mem_wr_addr       = rd_cnt_r[IW-1:0];
      mem_wr_data.valid = 1'b0;
    end else if ((state_r == ST_UPDATE) && found_r) begin
      if (req_r.req_type == REQ_PUT) begin
        mem_wr_en   = put_fits;
        mem_wr_data = '{valid: 1'b1, size: req_r.block_size, addr: req_r.block_addr};
      end else begin
        mem_wr_en         = 1'b1;
        mem_wr_data.valid = 1'b0;
      end
    end
  end

  assign upd = '{vld: (state_r == ST_UPDATE), found: found_r, req: req_r,
                 slot_size: hit_ent_r.size, slot_addr: hit_ent_r.addr};

endmodule

// ===== hdl/sbrc_stats.sv =====
module sbrc_stats import sbrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] capacity,
  input  upd_t              upd,
  output logic              put_fits,
  output logic              out_strobe,
  output out_word_t         out_word
);

  logic [SIZE_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]  hit_vol_r, hit_vol_nxt;
  logic [CNT_W-1:0]  miss_vol_r, miss_vol_nxt;
  logic              strobe_r;
  out_word_t         out_word_r, out_word_nxt;
  logic [SIZE_W:0]   put_sum;
  logic [CNT_W:0]    hit_vol_sum;
  logic [CNT_W:0]    miss_vol_sum;
  logic              get_ok;

  // Capacity check for a put
  assign put_sum  = {1'b0, held_r} + {1'b0, upd.req.block_size};
  assign put_fits = (put_sum <= {1'b0, capacity});

  assign hit_vol_sum  = {1'b0, hit_vol_r} + (CNT_W + 1)'(upd.req.block_size);
  assign miss_vol_sum = {1'b0, miss_vol_r} + (CNT_W + 1)'(upd.req.block_size);
  assign get_ok       = (upd.req.req_type == REQ_GET) && upd.found;

  // Apply the outcome of one request
  always_comb begin
    held_nxt     = held_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    hit_vol_nxt  = hit_vol_r;
    miss_vol_nxt = miss_vol_r;
    out_word_nxt = out_word_r;
    if (upd.vld) begin
      if (upd.req.req_type == REQ_PUT) begin
        if (upd.found && put_fits) begin
          held_nxt = put_sum[SIZE_W-1:0];
        end
      end else begin
        if (upd.found) begin
          held_nxt = (held_r >= upd.slot_size) ? held_r - upd.slot_size : '0;
        end
        if (!upd.req.any_size) begin
          if (upd.found) begin
            hit_cnt_nxt = (&hit_cnt_r) ? hit_cnt_r : hit_cnt_r + 1'b1;
            hit_vol_nxt = hit_vol_sum[CNT_W] ? '1 : hit_vol_sum[CNT_W-1:0];
          end else begin
            miss_cnt_nxt = (&miss_cnt_r) ? miss_cnt_r : miss_cnt_r + 1'b1;
            miss_vol_nxt = miss_vol_sum[CNT_W] ? '1 : miss_vol_sum[CNT_W-1:0];
          end
        end
      end
      out_word_nxt.success = (upd.req.req_type == REQ_PUT) ? (upd.found && put_fits)
                                                            : upd.found;
      out_word_nxt.returned_addr  = get_ok ? upd.slot_addr : '0;
      out_word_nxt.bytes_in_cache = held_nxt;
      out_word_nxt.hit_total      = hit_cnt_nxt;
      out_word_nxt.miss_total     = miss_cnt_nxt;
      out_word_nxt.hit_bytes      = hit_vol_nxt;
      out_word_nxt.miss_bytes     = miss_vol_nxt;
    end
  end

  // Hold counters and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      hit_vol_r  <= '0;
      miss_vol_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      hit_vol_r  <= hit_vol_nxt;
      miss_vol_r <= miss_vol_nxt;
      strobe_r   <= upd.vld;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== tb/tb_sized_block_reuse_cache.sv =====
`timescale 1ns / 100ps

module tb_sized_block_reuse_cache;
  import sbrc_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam logic [3:0] CAPACITY_ADDR = {REG_CAPACITY, 3'b000};
  localparam logic [SIZE_W-1:0] SIZE_ONES = '1;
  localparam logic [ADDR_W-1:0] MAX_ADDR = '1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_strobe;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // Shadow copy of the block: slot table, held bytes, counters, capacity
  logic              mdl_valid [SbrcSlots];
  logic [SIZE_W-1:0] mdl_size  [SbrcSlots];
  logic [ADDR_W-1:0] mdl_addr  [SbrcSlots];
  logic [SIZE_W-1:0] mdl_held;
  logic [CNT_W-1:0]  mdl_hits;
  logic [CNT_W-1:0]  mdl_misses;
  logic [CNT_W-1:0]  mdl_hit_vol;
  logic [CNT_W-1:0]  mdl_miss_vol;
  logic [SIZE_W-1:0] mdl_capacity;

  out_word_t awaited_words[$];
  out_word_t head_word;
  int        fail_count;
  int        cycle_count;
  int        n_put_ok, n_put_full, n_put_over, n_hit, n_miss, n_any_ok, n_any_empty;

  sized_block_reuse_cache DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Apply one request to the shadow table and return the word it must produce
  function automatic out_word_t cache_predict(input in_word_t w);
    out_word_t       r;
    int              pick;
    int              i;
    logic [SIZE_W:0] sum;
    r = '0;
    pick = -1;
    if (w.req_type == REQ_PUT) begin
      for (i = 0; i < SbrcSlots; i++)
        if (pick < 0 && !mdl_valid[i]) pick = i;
      sum = {1'b0, mdl_held} + {1'b0, w.block_size};
      if (pick >= 0 && sum <= {1'b0, mdl_capacity}) begin
        mdl_valid[pick] = 1'b1;
        mdl_size[pick]  = w.block_size;
        mdl_addr[pick]  = w.block_addr;
        mdl_held        = sum[SIZE_W-1:0];
        r.success       = 1'b1;
        n_put_ok++;
      end else if (pick < 0) begin
        n_put_full++;
      end else begin
        n_put_over++;
      end
    end else begin
      for (i = 0; i < SbrcSlots; i++)
        if (pick < 0 && mdl_valid[i] && (w.any_size || mdl_size[i] == w.block_size))
          pick = i;
      if (pick >= 0) begin
        r.success       = 1'b1;
        r.returned_addr = mdl_addr[pick];
        mdl_valid[pick] = 1'b0;
        mdl_held = (mdl_held >= mdl_size[pick]) ? mdl_held - mdl_size[pick] : '0;
      end
      if (w.any_size) begin
        if (pick >= 0) n_any_ok++;
        else n_any_empty++;
      end else if (pick >= 0) begin
        mdl_hits    = sat_sum(mdl_hits, CNT_W'(1));
        mdl_hit_vol = sat_sum(mdl_hit_vol, CNT_W'(w.block_size));
        n_hit++;
      end else begin
        mdl_misses   = sat_sum(mdl_misses, CNT_W'(1));
        mdl_miss_vol = sat_sum(mdl_miss_vol, CNT_W'(w.block_size));
        n_miss++;
      end
    end
    r.bytes_in_cache = mdl_held;
    r.hit_total      = mdl_hits;
    r.miss_total     = mdl_misses;
    r.hit_bytes      = mdl_hit_vol;
    r.miss_bytes     = mdl_miss_vol;
    return r;
  endfunction

  function automatic in_word_t req_word(input logic req, input logic any,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.req_type   = req;
    w.any_size   = any;
    w.block_size = size;
    w.block_addr = addr;
    return w;
  endfunction

  // Random request; sized gets mostly ask for a size that is cached right now
  function automatic in_word_t random_request(input int put_pct, input int big_pct);
    in_word_t    w;
    logic [63:0] r64;
    int          roll;
    int          first;
    int          idx;
    int          i;
    logic        found;
    r64  = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    w.block_addr = {$urandom(), $urandom()};
    w.any_size   = 1'($urandom_range(0, 1));
    if (roll >= big_pct) begin
      w.block_size = SIZE_W'($urandom_range(0, 15));
    end else begin
      unique case (roll % 4)
        0:       w.block_size = SIZE_ONES;
        1:       w.block_size = SIZE_W'(r64[19:0]);
        default: w.block_size = r64[SIZE_W-1:0];
      endcase
    end
    if ($urandom_range(0, 99) < put_pct) begin
      w.req_type = REQ_PUT;
    end else begin
      w.req_type = REQ_GET;
      w.any_size = ($urandom_range(0, 3) == 0);
      if (!w.any_size && $urandom_range(0, 9) < 6) begin
        first = $urandom_range(0, SbrcSlots - 1);
        found = 1'b0;
        for (i = 0; i < SbrcSlots; i++) begin
          idx = (first + i) % SbrcSlots;
          if (!found && mdl_valid[idx]) begin
            w.block_size = mdl_size[idx];
            found = 1'b1;
          end
        end
      end
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it; caller is at a falling edge
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_words.push_back(cache_predict(w));
    @(negedge clk);
  endtask

  // Wait for idle, write the capacity register, then read it back
  task automatic set_capacity(input logic [SIZE_W-1:0] value);
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mdl_capacity = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[SIZE_W-1:0] !== value) begin
      fail_count++;
      $display("%0t: capacity read back expected %h, got %h", $time, value,
               prdata[SIZE_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Send random words in bursts with gaps, now and then draining all results
  task automatic run_random(input int count, input int put_pct, input int big_pct);
    int burst_left;
    int gap;
    int k;
    burst_left = 0;
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
        repeat (gap) @(negedge clk);
        if ($urandom_range(0, 15) == 0)
          while (awaited_words.size() != 0) @(negedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      send_word(random_request(put_pct, big_pct));
      burst_left--;
    end
    start <= 1'b0;
  endtask

  // Empty-table gets, zero-size put at zero capacity, refusals, lowest-index picks
  task automatic test_directed();
    set_capacity('0);
    send_word(req_word(REQ_GET, 1'b1, SIZE_ONES, MAX_ADDR));
    send_word(req_word(REQ_GET, 1'b0, '0, '0));
    send_word(req_word(REQ_GET, 1'b0, SIZE_ONES, MAX_ADDR));
    send_word(req_word(REQ_PUT, 1'b0, '0, MAX_ADDR));
    send_word(req_word(REQ_PUT, 1'b0, 48'd1, '0));
    send_word(req_word(REQ_GET, 1'b0, '0, '0));
    start <= 1'b0;
    set_capacity(SIZE_ONES);
    send_word(req_word(REQ_PUT, 1'b0, SIZE_ONES, 64'haaaa_aaaa_aaaa_aaaa));
    send_word(req_word(REQ_PUT, 1'b0, '0, 64'h5555_5555_5555_5555));
    send_word(req_word(REQ_PUT, 1'b0, 48'd1, 64'h1));
    send_word(req_word(REQ_GET, 1'b0, SIZE_ONES, '0));
    send_word(req_word(REQ_GET, 1'b1, '0, '0));
    send_word(req_word(REQ_PUT, 1'b0, 48'd5, 64'h100));
    send_word(req_word(REQ_PUT, 1'b0, 48'd7, 64'h200));
    send_word(req_word(REQ_PUT, 1'b0, 48'd5, 64'h300));
    send_word(req_word(REQ_PUT, 1'b0, 48'd9, 64'h400));
    send_word(req_word(REQ_GET, 1'b0, 48'd5, MAX_ADDR));
    send_word(req_word(REQ_GET, 1'b0, 48'd5, '0));
    send_word(req_word(REQ_GET, 1'b0, 48'd5, '0));
    send_word(req_word(REQ_GET, 1'b1, 48'd5, '0));
    send_word(req_word(REQ_GET, 1'b1, '0, '0));
    send_word(req_word(REQ_GET, 1'b1, '0, '0));
    send_word(req_word(REQ_PUT, 1'b1, 48'd3, 64'h8000_0000_0000_0000));
    send_word(req_word(REQ_GET, 1'b0, 48'd3, '0));
    start <= 1'b0;
  endtask

  // Mostly small puts at full capacity, so the table runs full
  task automatic test_table_fill();
    set_capacity(SIZE_ONES);
    run_random(450, 75, 0);
  endtask

  // Small capacity: many puts refused for bytes
  task automatic test_tight_capacity();
    set_capacity(48'd200);
    run_random(350, 55, 10);
  endtask

  task automatic test_random_capacity();
    set_capacity(SIZE_W'({$urandom(), $urandom()}));
    run_random(350, 50, 40);
  endtask

  // Zero capacity: only zero-size puts fit once the table drains
  task automatic test_zero_capacity();
    set_capacity('0);
    run_random(150, 50, 20);
  endtask

  // Get-heavy mix with wide sizes
  task automatic test_drain();
    set_capacity(SIZE_ONES);
    run_random(500, 35, 30);
  endtask

  // Compare each result word with the oldest prediction
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_words.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word %h", $time, out_word);
      end else begin
        head_word = awaited_words.pop_front();
        check_field("success", 64'(head_word.success), 64'(out_word.success));
        check_field("returned_addr", head_word.returned_addr, out_word.returned_addr);
        check_field("bytes_in_cache", 64'(head_word.bytes_in_cache),
                    64'(out_word.bytes_in_cache));
        check_field("hit_total", head_word.hit_total, out_word.hit_total);
        check_field("miss_total", head_word.miss_total, out_word.miss_total);
        check_field("hit_bytes", head_word.hit_bytes, out_word.hit_bytes);
        check_field("miss_bytes", head_word.miss_bytes, out_word.miss_bytes);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    cycle_count = 0;
    n_put_ok = 0; n_put_full = 0; n_put_over = 0;
    n_hit = 0; n_miss = 0; n_any_ok = 0; n_any_empty = 0;
    foreach (mdl_valid[i]) begin
      mdl_valid[i] = 1'b0;
      mdl_size[i]  = '0;
      mdl_addr[i]  = '0;
    end
    mdl_held = '0; mdl_hits = '0; mdl_misses = '0;
    mdl_hit_vol = '0; mdl_miss_vol = '0; mdl_capacity = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // Let the clearing pass finish
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    test_directed();
    test_table_fill();
    test_tight_capacity();
    test_random_capacity();
    test_zero_capacity();
    test_drain();

    // Drain, then allow one more full scan for stray words
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (SbrcSlots + 8) @(negedge clk);
    if (awaited_words.size() != 0) begin
      fail_count++;
      $display("%0t: %0d result words never arrived", $time, awaited_words.size());
    end

    $display("Puts: %0d stored, %0d refused on full table, %0d refused on capacity",
             n_put_ok, n_put_full, n_put_over);
    $display("Gets: %0d sized hits, %0d sized misses, %0d any-size taken, %0d on empty",
             n_hit, n_miss, n_any_ok, n_any_empty);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
